[sv/mamc_pkg.sv]
// ----------------------------------------------------------------------------
// mamc_pkg: shared types and constants for the moving average / median block
// Sample and sum widths, the result word layout and the verdict codes.
// ----------------------------------------------------------------------------
package mamc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 26;
    localparam int IN_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = 3 * SAMPLE_W + 2 * SUM_W + 2;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_AVG   = 2'd1,
        VERDICT_MED   = 2'd2,
        VERDICT_EQUAL = 2'd3
    } t_verdict;

    // One result; the first field listed sits in the highest bits.
    typedef struct packed {
        logic                       last;
        t_verdict                   verdict;
        logic [SUM_W-1:0]           med_sum;
        logic [SUM_W-1:0]           avg_sum;
        logic signed [SAMPLE_W-1:0] median;
        logic signed [SAMPLE_W-1:0] average;
        logic signed [SAMPLE_W-1:0] original;
    } t_result;

endpackage

[sv/mamc_res_fifo.sv]
// ----------------------------------------------------------------------------
// mamc_res_fifo: result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module mamc_res_fifo import mamc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_push_cnt,
    input  t_result    i_entry_a,
    input  t_result    i_entry_b,
    input  logic       i_pop_ready,
    output logic       o_room,
    output logic       o_valid,
    output t_result    o_head
);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid & i_pop_ready;
    // Room for two more words, the most one cycle can push.
    assign o_room  = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_head  = r_mem[r_rd_ptr];
    assign n_count = r_count + CNT_W'(i_push_cnt) - CNT_W'(w_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_cnt);
            r_rd_ptr <= r_rd_ptr + PTR_W'(w_pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_entry_a;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr_ptr + PTR_W'(1)] <= i_entry_b;
        end
    end

endmodule

[sv/moving_average_median_compare.sv]
// ----------------------------------------------------------------------------
// moving_average_median_compare: 3-point average and median filter compare
// Filters a sample stream with a 3-point mean and a 3-point median, keeps
// saturating sums of deviations and gives a verdict on the last result.
// ----------------------------------------------------------------------------
// Channel   Dir  Word                          Last
// s_axis    in   tdata: sample                 tlast: end_of_stream
// m_axis    out  tdata: filtered result        tlast: last_result
//
// One input word is taken per cycle while the queue has room; a result goes
// from the word that completes it through the pipeline and a four-word queue.
// A stream's first word yields no result and its end-of-stream word yields two
// (one if also the first); the input stalls only when fewer than two queue
// slots are free. Output stalls back up through the queue into the pipeline.
// Reset is synchronous; it clears the window fill count, sums and queue.
// ----------------------------------------------------------------------------
module moving_average_median_compare import mamc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // [15:0] sample
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [15:0] original_value, [31:16] average_value, [47:32] median_value,
    // [73:48] average_deviation_sum, [99:74] median_deviation_sum,
    // [101:100] verdict, rest zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast
);

    localparam int WSUM_W      = SAMPLE_W + 2;
    localparam int ABS_W       = SAMPLE_W + 1;
    localparam int RECIP_SHIFT = SAMPLE_W + 1;
    localparam int RECIP       = (2 ** RECIP_SHIFT + 2) / 3;
    localparam int PROD_W      = ABS_W + SAMPLE_W;
    localparam logic [1:0] SEEN_FULL = 2'd2;

    typedef struct packed {
        logic                       has_mid;
        logic                       filt;
        logic                       eos;
        logic signed [SAMPLE_W-1:0] orig;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] med;
        logic [ABS_W-1:0]           mag;
        logic                       neg;
    } t_stage1;

    typedef struct packed {
        logic                       has_mid;
        logic                       filt;
        logic                       eos;
        logic signed [SAMPLE_W-1:0] orig;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] med;
        logic [SAMPLE_W-1:0]        quot;
        logic                       neg;
    } t_stage2;

    typedef struct packed {
        logic                       has_mid;
        logic                       eos;
        logic signed [SAMPLE_W-1:0] orig;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] avg;
        logic signed [SAMPLE_W-1:0] med;
        logic [SAMPLE_W-1:0]        dev_avg;
        logic [SAMPLE_W-1:0]        dev_med;
    } t_stage3;

    function automatic logic signed [SAMPLE_W-1:0] mid3(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input logic signed [SAMPLE_W-1:0] c
    );
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic signed [SAMPLE_W-1:0] res;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) begin
            res = lo;
        end else if (c >= hi) begin
            res = hi;
        end else begin
            res = c;
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] abs_diff(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b
    );
        logic signed [SAMPLE_W:0] d;
        d = (SAMPLE_W+1)'(a) - (SAMPLE_W+1)'(b);
        if (d < 0) begin
            d = -d;
        end
        return d[SAMPLE_W-1:0];
    endfunction

    // Window and accumulators
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [SAMPLE_W-1:0] r_older;
    logic [1:0]                 r_seen;
    logic [SUM_W-1:0]           r_avg_sum;
    logic [SUM_W-1:0]           r_med_sum;

    // Pipeline
    logic    r_v1, r_v2, r_v3;
    t_stage1 r_s1, n_s1;
    t_stage2 r_s2, n_s2;
    t_stage3 r_s3, n_s3;

    logic                       w_advance;
    logic                       w_accept;
    logic signed [SAMPLE_W-1:0] w_x;
    logic signed [WSUM_W-1:0]   w_sum;
    logic signed [WSUM_W-1:0]   w_mag_full;
    logic [PROD_W-1:0]          w_prod;
    logic signed [SAMPLE_W:0]   w_avg_wide;
    logic signed [SAMPLE_W-1:0] w_avg;
    logic [SUM_W:0]             w_avg_add;
    logic [SUM_W:0]             w_med_add;
    logic [SUM_W-1:0]           n_avg_sum;
    logic [SUM_W-1:0]           n_med_sum;
    t_verdict                   w_verdict;
    logic                       w_push_go;
    logic [1:0]                 w_push_cnt;
    t_result                    w_mid_res;
    t_result                    w_end_res;
    t_result                    w_entry_a;
    t_result                    w_head;
    logic                       w_out_valid;

    assign o_s_axis_tready = w_advance;
    assign w_accept        = i_s_axis_tvalid & w_advance;
    assign w_x             = i_s_axis_tdata[SAMPLE_W-1:0];

    // Stage 1: window sum magnitude and median.
    assign w_sum      = WSUM_W'(r_older) + WSUM_W'(r_prev) + WSUM_W'(w_x);
    assign w_mag_full = w_sum[WSUM_W-1] ? -w_sum : w_sum;

    always_comb begin
        n_s1.has_mid = (r_seen != 2'd0);
        n_s1.filt    = (r_seen == SEEN_FULL);
        n_s1.eos     = i_s_axis_tlast;
        n_s1.orig    = r_prev;
        n_s1.x       = w_x;
        n_s1.med     = mid3(r_older, r_prev, w_x);
        n_s1.mag     = w_mag_full[ABS_W-1:0];
        n_s1.neg     = w_sum[WSUM_W-1];
    end

    // Stage 2: divide the magnitude by three with a reciprocal multiply.
    assign w_prod = PROD_W'(r_s1.mag) * PROD_W'(RECIP);

    always_comb begin
        n_s2.has_mid = r_s1.has_mid;
        n_s2.filt    = r_s1.filt;
        n_s2.eos     = r_s1.eos;
        n_s2.orig    = r_s1.orig;
        n_s2.x       = r_s1.x;
        n_s2.med     = r_s1.med;
        n_s2.quot    = w_prod[RECIP_SHIFT +: SAMPLE_W];
        n_s2.neg     = r_s1.neg;
    end

    // Stage 3: restore the sign and form the deviations.
    assign w_avg_wide = r_s2.neg ? -$signed({1'b0, r_s2.quot}) : $signed({1'b0, r_s2.quot});
    assign w_avg      = w_avg_wide[SAMPLE_W-1:0];

    always_comb begin
        n_s3.has_mid = r_s2.has_mid;
        n_s3.eos     = r_s2.eos;
        n_s3.orig    = r_s2.orig;
        n_s3.x       = r_s2.x;
        // Near the stream start the sample passes through unchanged.
        n_s3.avg     = r_s2.filt ? w_avg : r_s2.orig;
        n_s3.med     = r_s2.filt ? r_s2.med : r_s2.orig;
        n_s3.dev_avg = r_s2.filt ? abs_diff(r_s2.orig, w_avg) : '0;
        n_s3.dev_med = r_s2.filt ? abs_diff(r_s2.orig, r_s2.med) : '0;
    end

    // Stage 4: accumulate, decide and push into the result queue.
    assign w_avg_add = (SUM_W+1)'(r_avg_sum) + (SUM_W+1)'(r_s3.dev_avg);
    assign w_med_add = (SUM_W+1)'(r_med_sum) + (SUM_W+1)'(r_s3.dev_med);
    assign n_avg_sum = w_avg_add[SUM_W] ? SUM_MAX : w_avg_add[SUM_W-1:0];
    assign n_med_sum = w_med_add[SUM_W] ? SUM_MAX : w_med_add[SUM_W-1:0];

    always_comb begin
        if (n_avg_sum < n_med_sum) begin
            w_verdict = VERDICT_AVG;
        end else if (n_med_sum < n_avg_sum) begin
            w_verdict = VERDICT_MED;
        end else begin
            w_verdict = VERDICT_EQUAL;
        end
    end

    always_comb begin
        w_mid_res.last     = 1'b0;
        w_mid_res.verdict  = VERDICT_NONE;
        w_mid_res.med_sum  = n_med_sum;
        w_mid_res.avg_sum  = n_avg_sum;
        w_mid_res.median   = r_s3.med;
        w_mid_res.average  = r_s3.avg;
        w_mid_res.original = r_s3.orig;

        w_end_res.last     = 1'b1;
        w_end_res.verdict  = w_verdict;
        w_end_res.med_sum  = n_med_sum;
        w_end_res.avg_sum  = n_avg_sum;
        w_end_res.median   = r_s3.x;
        w_end_res.average  = r_s3.x;
        w_end_res.original = r_s3.x;
    end

    assign w_push_go  = r_v3 & w_advance;
    assign w_entry_a  = r_s3.has_mid ? w_mid_res : w_end_res;
    assign w_push_cnt = w_push_go ? (2'(r_s3.has_mid) + 2'(r_s3.eos)) : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_avg_sum <= '0;
            r_med_sum <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
        end else begin
            if (w_advance) begin
                r_v1 <= w_accept;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
            if (w_accept) begin
                if (i_s_axis_tlast) begin
                    r_seen <= '0;
                end else if (r_seen != SEEN_FULL) begin
                    r_seen <= r_seen + 2'd1;
                end
            end
            if (w_push_go) begin
                if (r_s3.eos) begin
                    r_avg_sum <= '0;
                    r_med_sum <= '0;
                end else begin
                    r_avg_sum <= n_avg_sum;
                    r_med_sum <= n_med_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_older <= r_prev;
            r_prev  <= w_x;
        end
        if (w_advance) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    mamc_res_fifo u_res_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (w_push_cnt),
        .i_entry_a   (w_entry_a),
        .i_entry_b   (w_end_res),
        .i_pop_ready (i_m_axis_tready),
        .o_room      (w_advance),
        .o_valid     (w_out_valid),
        .o_head      (w_head)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tlast  = w_head.last;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, w_head.verdict,
                              w_head.med_sum, w_head.avg_sum, w_head.median,
                              w_head.average, w_head.original};

`ifndef SYNTHESIS
    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_v1)
        else $error("accepted word did not enter the pipeline");

    a_sums_clear_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_go && r_s3.eos) |=> (r_avg_sum == '0 && r_med_sum == '0))
        else $error("deviation sums not cleared after stream end");

    a_verdict_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (w_head.verdict != VERDICT_NONE)))
        else $error("verdict does not match the last flag");

    a_seen_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("window fill count out of range");
`endif

endmodule
